@@ hw/rtl/wrac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrac_pkg: shared types and constants
// Payload structs, command and register codes, sequencer states and helper
// functions for the waveform range aggregator.
// ----------------------------------------------------------------------------
package wrac_pkg;

    localparam int POINT_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(POINT_DEPTH);
    localparam int CNT_W       = 13;
    localparam int DUR_W       = 27;
    localparam int CFG_W       = 27;
    localparam int PROD_W      = 44;
    localparam int QUO_W       = 17;
    localparam int DIV_STEPS   = QUO_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);
    localparam int FADE_MS     = 420;
    localparam int FADE_DEN    = FADE_MS * FADE_MS * FADE_MS;
    localparam int MIX_ONE     = 65536;
    localparam int HALF_LSB    = 32768;
    localparam int RANGE_PAD   = 5;

    typedef enum logic [1:0] {
        CMD_LOAD_CUR  = 2'd0,
        CMD_LOAD_PREV = 2'd1,
        CMD_POINT     = 2'd2,
        CMD_RANGE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_CUR_COUNT  = 2'd0,
        CFG_CUR_DUR    = 2'd1,
        CFG_PREV_COUNT = 2'd2,
        CFG_PREV_DUR   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DK_BEGIN,
        DK_FINAL,
        DK_MEAN,
        DK_MIX
    } div_kind_t;

    typedef enum logic [2:0] {
        FLD_PEAK,
        FLD_RMS,
        FLD_BASS,
        FLD_MIDS,
        FLD_TREBLE
    } fld_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_B,
        ST_MUL_F,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WALK,
        ST_MIX_SQ,
        ST_MIX_CUBE,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [11:0] entry_index;
        logic [15:0] peak_in;
        logic [15:0] rms_in;
        logic [7:0]  bass_in;
        logic [7:0]  mids_in;
        logic [7:0]  treble_in;
        logic [26:0] start_ms;
        logic [26:0] end_ms;
        logic [9:0]  fade_elapsed_ms;
    } req_t;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] peak_out;
        logic [15:0] rms_out;
        logic [7:0]  bass_out;
        logic [7:0]  mids_out;
        logic [7:0]  treble_out;
    } rsp_t;

    typedef struct packed {
        logic [15:0] peak;
        logic [15:0] rms;
        logic [7:0]  bass;
        logic [7:0]  mids;
        logic [7:0]  treble;
    } point_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        begin
            r = c;
            if (32'(c) > POINT_DEPTH)
            begin
                r = CNT_W'(POINT_DEPTH);
            end
            return r;
        end
    endfunction

    function automatic logic [15:0] field_get(input point_t p, input fld_t k);
        logic [15:0] v;
        begin
            v = '0;
            case (k)
                FLD_PEAK:   v = p.peak;
                FLD_RMS:    v = p.rms;
                FLD_BASS:   v = {8'd0, p.bass};
                FLD_MIDS:   v = {8'd0, p.mids};
                FLD_TREBLE: v = {8'd0, p.treble};
                default:    v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic point_t field_set(input point_t p, input fld_t k,
                                         input logic [15:0] v);
        point_t r;
        begin
            r = p;
            case (k)
                FLD_PEAK:   r.peak   = v;
                FLD_RMS:    r.rms    = v;
                FLD_BASS:   r.bass   = v[7:0];
                FLD_MIDS:   r.mids   = v[7:0];
                FLD_TREBLE: r.treble = v[7:0];
                default:    r = p;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/waveform_range_aggregate_crossfade.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_range_aggregate_crossfade: waveform point table range aggregator
// Load transactions write one table entry and finish in the accept cycle.
// A query divides to find the begin entry (a range query also the final entry),
// walks the spanned entries of the table and divides for each mean field.
// A fade adds a pass over the previous table and a blend; busy holds until done.
// Reset clears config and control; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module waveform_range_aggregate_crossfade (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  wrac_pkg::req_t             req,
    output logic                       busy,
    output logic                       done,
    output wrac_pkg::rsp_t             rsp,
    input  logic                       cfg_write,
    input  wrac_pkg::cfg_idx_t         cfg_index,
    input  logic [wrac_pkg::CFG_W-1:0] cfg_data
);

    wrac_pkg::state_t                state_reg, state_next;
    logic [wrac_pkg::CNT_W-1:0]      cur_cnt_reg, prev_cnt_reg;
    logic [wrac_pkg::DUR_W-1:0]      cur_dur_reg, prev_dur_reg;

    logic                            phase_reg, phase_next;
    wrac_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [26:0]                     s_reg, s_next;
    logic [26:0]                     e_reg, e_next;
    logic [9:0]                      el_reg, el_next;
    logic [wrac_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic [wrac_pkg::DUR_W-1:0]      den_reg, den_next;
    wrac_pkg::div_kind_t             kind_reg, kind_next;
    logic [wrac_pkg::CNT_W-1:0]      b_reg, b_next;
    logic [wrac_pkg::CNT_W-1:0]      f_reg, f_next;
    logic [wrac_pkg::CNT_W-1:0]      ptr_reg, ptr_next;
    logic                            rdv_reg, rdv_next;
    logic [15:0]                     peak_acc_reg, peak_acc_next;
    logic [27:0]                     rms_acc_reg, rms_acc_next;
    logic [19:0]                     bass_acc_reg, bass_acc_next;
    logic [19:0]                     mids_acc_reg, mids_acc_next;
    logic [19:0]                     treble_acc_reg, treble_acc_next;
    wrac_pkg::fld_t                  fld_reg, fld_next;
    wrac_pkg::point_t                tpt_reg, tpt_next;
    wrac_pkg::point_t                cur_pt_reg, cur_pt_next;
    logic [wrac_pkg::QUO_W-1:0]      m_reg, m_next;
    logic                            res_valid_reg, res_valid_next;
    wrac_pkg::point_t                res_reg, res_next;

    logic [wrac_pkg::CNT_W-1:0]      tcnt;
    logic [wrac_pkg::DUR_W-1:0]      tdur;
    logic [26:0]                     s_cl;
    logic [27:0]                     e_raw;
    logic [26:0]                     e_cl;
    logic [26:0]                     mul_a;
    logic [16:0]                     mul_b;
    logic [wrac_pkg::PROD_W-1:0]     product;
    logic                            div_start;
    logic                            div_done;
    logic [wrac_pkg::QUO_W-1:0]      div_quo;
    logic [wrac_pkg::CNT_W-1:0]      b_clamp;
    logic [wrac_pkg::CNT_W-1:0]      f_clamp;
    logic                            accept;
    logic                            is_query;
    logic                            load_ok;
    logic                            cur_invalid;
    logic                            fade_ok;
    logic                            walk_end;
    logic [wrac_pkg::PROD_W-1:0]     blend_sum;
    wrac_pkg::point_t                wpoint;
    wrac_pkg::point_t                rd_cur, rd_prev, rd_sel;
    wrac_pkg::point_t                mean_pt;

    assign accept      = start && !busy;
    assign is_query    = (req.cmd == wrac_pkg::CMD_POINT) || (req.cmd == wrac_pkg::CMD_RANGE);
    assign load_ok     = (32'(req.entry_index) < wrac_pkg::POINT_DEPTH);
    assign cur_invalid = (cur_cnt_reg == '0) || (cur_dur_reg == '0);
    assign fade_ok     = (el_reg < 10'(wrac_pkg::FADE_MS)) && (prev_cnt_reg != '0)
                         && (prev_dur_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_cnt_reg  <= '0;
            cur_dur_reg  <= '0;
            prev_cnt_reg <= '0;
            prev_dur_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wrac_pkg::CFG_CUR_COUNT:  cur_cnt_reg  <= cfg_data[wrac_pkg::CNT_W-1:0];
                wrac_pkg::CFG_CUR_DUR:    cur_dur_reg  <= cfg_data;
                wrac_pkg::CFG_PREV_COUNT: prev_cnt_reg <= cfg_data[wrac_pkg::CNT_W-1:0];
                wrac_pkg::CFG_PREV_DUR:   prev_dur_reg <= cfg_data;
                default:                  cur_cnt_reg  <= cur_cnt_reg;
            endcase
        end
    end

    assign wpoint = '{peak: req.peak_in, rms: req.rms_in, bass: req.bass_in,
                      mids: req.mids_in, treble: req.treble_in};

    wrac_ram u_ram_cur (
        .clk   (clk),
        .we    (accept && (req.cmd == wrac_pkg::CMD_LOAD_CUR) && load_ok),
        .waddr (wrac_pkg::ADDR_W'(req.entry_index)),
        .wdata (wpoint),
        .raddr (wrac_pkg::ADDR_W'(ptr_reg)),
        .rdata (rd_cur)
    );

    wrac_ram u_ram_prev (
        .clk   (clk),
        .we    (accept && (req.cmd == wrac_pkg::CMD_LOAD_PREV) && load_ok),
        .waddr (wrac_pkg::ADDR_W'(req.entry_index)),
        .wdata (wpoint),
        .raddr (wrac_pkg::ADDR_W'(ptr_reg)),
        .rdata (rd_prev)
    );

    wrac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign rd_sel  = phase_reg ? rd_prev : rd_cur;
    assign tcnt    = phase_reg ? wrac_pkg::eff_count(prev_cnt_reg)
                               : wrac_pkg::eff_count(cur_cnt_reg);
    assign tdur    = phase_reg ? prev_dur_reg : cur_dur_reg;
    assign s_cl    = (s_reg > tdur) ? tdur : s_reg;
    assign e_raw   = (e_reg <= s_reg) ? ({1'b0, s_reg} + 28'(wrac_pkg::RANGE_PAD))
                                      : {1'b0, e_reg};
    assign e_cl    = (e_raw > {1'b0, tdur}) ? tdur : e_raw[26:0];
    assign product = wrac_pkg::PROD_W'(mul_a) * wrac_pkg::PROD_W'(mul_b);
    assign b_clamp = ({{(wrac_pkg::QUO_W-wrac_pkg::CNT_W){1'b0}}, tcnt - 1'b1} < div_quo)
                     ? (tcnt - 1'b1) : div_quo[wrac_pkg::CNT_W-1:0];
    assign f_clamp = ({{(wrac_pkg::QUO_W-wrac_pkg::CNT_W){1'b0}}, tcnt} < div_quo)
                     ? tcnt : div_quo[wrac_pkg::CNT_W-1:0];
    assign walk_end  = (ptr_reg >= f_reg) && !rdv_reg;
    assign blend_sum = prod_reg + product + wrac_pkg::PROD_W'(wrac_pkg::HALF_LSB);
    assign mean_pt   = wrac_pkg::field_set(tpt_reg, fld_reg, div_quo[15:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrac_pkg::ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = cur_invalid ? wrac_pkg::ST_FINISH : wrac_pkg::ST_MUL_B;
                end
            end
            wrac_pkg::ST_MUL_B:    state_next = wrac_pkg::ST_DIV_GO;
            wrac_pkg::ST_MUL_F:    state_next = wrac_pkg::ST_DIV_GO;
            wrac_pkg::ST_DIV_GO:   state_next = wrac_pkg::ST_DIV_WAIT;
            wrac_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (kind_reg)
                        wrac_pkg::DK_BEGIN:
                            state_next = (cmd_reg == wrac_pkg::CMD_POINT)
                                         ? wrac_pkg::ST_WALK : wrac_pkg::ST_MUL_F;
                        wrac_pkg::DK_FINAL:
                            state_next = wrac_pkg::ST_WALK;
                        wrac_pkg::DK_MEAN:
                        begin
                            if (fld_reg != wrac_pkg::FLD_TREBLE)
                            begin
                                state_next = wrac_pkg::ST_DIV_GO;
                            end
                            else if (phase_reg)
                            begin
                                state_next = wrac_pkg::ST_MIX_SQ;
                            end
                            else
                            begin
                                state_next = fade_ok ? wrac_pkg::ST_MUL_B
                                                     : wrac_pkg::ST_FINISH;
                            end
                        end
                        wrac_pkg::DK_MIX:
                            state_next = (div_quo < wrac_pkg::QUO_W'(wrac_pkg::MIX_ONE))
                                         ? wrac_pkg::ST_BLEND_A : wrac_pkg::ST_FINISH;
                        default:
                            state_next = wrac_pkg::ST_IDLE;
                    endcase
                end
            end
            wrac_pkg::ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = wrac_pkg::ST_DIV_GO;
                end
            end
            wrac_pkg::ST_MIX_SQ:   state_next = wrac_pkg::ST_MIX_CUBE;
            wrac_pkg::ST_MIX_CUBE: state_next = wrac_pkg::ST_DIV_GO;
            wrac_pkg::ST_BLEND_A:  state_next = wrac_pkg::ST_BLEND_B;
            wrac_pkg::ST_BLEND_B:
            begin
                state_next = (fld_reg == wrac_pkg::FLD_TREBLE)
                             ? wrac_pkg::ST_FINISH : wrac_pkg::ST_BLEND_A;
            end
            wrac_pkg::ST_FINISH:   state_next = wrac_pkg::ST_IDLE;
            default:               state_next = wrac_pkg::ST_IDLE;
        endcase
    end

    // unit controls and handshake outputs
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        busy      = (state_reg != wrac_pkg::ST_IDLE);
        done      = (state_reg == wrac_pkg::ST_FINISH);
        unique case (state_reg)
            wrac_pkg::ST_MUL_B:
            begin
                mul_a = s_cl;
                mul_b = 17'(tcnt);
            end
            wrac_pkg::ST_MUL_F:
            begin
                mul_a = e_cl;
                mul_b = 17'(tcnt);
            end
            wrac_pkg::ST_DIV_GO:
            begin
                div_start = 1'b1;
            end
            wrac_pkg::ST_MIX_SQ:
            begin
                mul_a = 27'(el_reg);
                mul_b = 17'(el_reg);
            end
            wrac_pkg::ST_MIX_CUBE:
            begin
                mul_a = 27'(prod_reg[19:0]);
                mul_b = 17'(3 * wrac_pkg::FADE_MS) - 17'({el_reg, 1'b0});
            end
            wrac_pkg::ST_BLEND_A:
            begin
                mul_a = 27'(wrac_pkg::field_get(tpt_reg, fld_reg));
                mul_b = 17'(wrac_pkg::MIX_ONE) - m_reg;
            end
            wrac_pkg::ST_BLEND_B:
            begin
                mul_a = 27'(wrac_pkg::field_get(cur_pt_reg, fld_reg));
                mul_b = m_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        el_next         = el_reg;
        prod_next       = prod_reg;
        den_next        = den_reg;
        kind_next       = kind_reg;
        b_next          = b_reg;
        f_next          = f_reg;
        ptr_next        = ptr_reg;
        rdv_next        = 1'b0;
        peak_acc_next   = peak_acc_reg;
        rms_acc_next    = rms_acc_reg;
        bass_acc_next   = bass_acc_reg;
        mids_acc_next   = mids_acc_reg;
        treble_acc_next = treble_acc_reg;
        fld_next        = fld_reg;
        tpt_next        = tpt_reg;
        cur_pt_next     = cur_pt_reg;
        m_next          = m_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        unique case (state_reg)
            wrac_pkg::ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    cmd_next       = req.cmd;
                    s_next         = req.start_ms;
                    e_next         = req.end_ms;
                    el_next        = req.fade_elapsed_ms;
                    phase_next     = 1'b0;
                    res_valid_next = !cur_invalid;
                    res_next       = '0;
                end
            end
            wrac_pkg::ST_MUL_B:
            begin
                prod_next = product;
                den_next  = tdur;
                kind_next = wrac_pkg::DK_BEGIN;
            end
            wrac_pkg::ST_MUL_F:
            begin
                prod_next = product + wrac_pkg::PROD_W'(tdur) - 1'b1;
                den_next  = tdur;
                kind_next = wrac_pkg::DK_FINAL;
            end
            wrac_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (kind_reg)
                        wrac_pkg::DK_BEGIN:
                        begin
                            b_next          = b_clamp;
                            f_next          = b_clamp + 1'b1;
                            ptr_next        = b_clamp;
                            peak_acc_next   = '0;
                            rms_acc_next    = '0;
                            bass_acc_next   = '0;
                            mids_acc_next   = '0;
                            treble_acc_next = '0;
                        end
                        wrac_pkg::DK_FINAL:
                        begin
                            f_next = (f_clamp < b_reg + 1'b1) ? (b_reg + 1'b1) : f_clamp;
                        end
                        wrac_pkg::DK_MEAN:
                        begin
                            tpt_next = mean_pt;
                            if (fld_reg != wrac_pkg::FLD_TREBLE)
                            begin
                                fld_next  = wrac_pkg::fld_t'(fld_reg + 1'b1);
                                kind_next = wrac_pkg::DK_MEAN;
                                case (fld_reg)
                                    wrac_pkg::FLD_RMS:
                                        prod_next = wrac_pkg::PROD_W'(bass_acc_reg);
                                    wrac_pkg::FLD_BASS:
                                        prod_next = wrac_pkg::PROD_W'(mids_acc_reg);
                                    default:
                                        prod_next = wrac_pkg::PROD_W'(treble_acc_reg);
                                endcase
                            end
                            else if (!phase_reg)
                            begin
                                cur_pt_next = mean_pt;
                                res_next    = mean_pt;
                                if (fade_ok)
                                begin
                                    phase_next = 1'b1;
                                end
                            end
                        end
                        wrac_pkg::DK_MIX:
                        begin
                            m_next   = div_quo;
                            fld_next = wrac_pkg::FLD_PEAK;
                        end
                        default:
                        begin
                            m_next = m_reg;
                        end
                    endcase
                end
            end
            wrac_pkg::ST_WALK:
            begin
                if (ptr_reg < f_reg)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    rdv_next = 1'b1;
                end
                if (rdv_reg)
                begin
                    if (rd_sel.peak > peak_acc_reg)
                    begin
                        peak_acc_next = rd_sel.peak;
                    end
                    rms_acc_next    = rms_acc_reg + 28'(rd_sel.rms);
                    bass_acc_next   = bass_acc_reg + 20'(rd_sel.bass);
                    mids_acc_next   = mids_acc_reg + 20'(rd_sel.mids);
                    treble_acc_next = treble_acc_reg + 20'(rd_sel.treble);
                end
                if (walk_end)
                begin
                    tpt_next      = '0;
                    tpt_next.peak = peak_acc_reg;
                    fld_next      = wrac_pkg::FLD_RMS;
                    prod_next     = wrac_pkg::PROD_W'(rms_acc_reg);
                    den_next      = wrac_pkg::DUR_W'(f_reg - b_reg);
                    kind_next     = wrac_pkg::DK_MEAN;
                end
            end
            wrac_pkg::ST_MIX_SQ:
            begin
                prod_next = product;
            end
            wrac_pkg::ST_MIX_CUBE:
            begin
                prod_next = {product[27:0], 16'd0}
                            + wrac_pkg::PROD_W'(wrac_pkg::FADE_DEN / 2);
                den_next  = wrac_pkg::DUR_W'(wrac_pkg::FADE_DEN);
                kind_next = wrac_pkg::DK_MIX;
            end
            wrac_pkg::ST_BLEND_A:
            begin
                prod_next = product;
            end
            wrac_pkg::ST_BLEND_B:
            begin
                res_next = wrac_pkg::field_set(res_reg, fld_reg, blend_sum[31:16]);
                if (fld_reg != wrac_pkg::FLD_TREBLE)
                begin
                    fld_next = wrac_pkg::fld_t'(fld_reg + 1'b1);
                end
            end
            default:
            begin
                rdv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wrac_pkg::ST_IDLE;
            rdv_reg   <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= rdv_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        el_reg         <= el_next;
        prod_reg       <= prod_next;
        den_reg        <= den_next;
        kind_reg       <= kind_next;
        b_reg          <= b_next;
        f_reg          <= f_next;
        ptr_reg        <= ptr_next;
        peak_acc_reg   <= peak_acc_next;
        rms_acc_reg    <= rms_acc_next;
        bass_acc_reg   <= bass_acc_next;
        mids_acc_reg   <= mids_acc_next;
        treble_acc_reg <= treble_acc_next;
        fld_reg        <= fld_next;
        tpt_reg        <= tpt_next;
        cur_pt_reg     <= cur_pt_next;
        m_reg          <= m_next;
        res_valid_reg  <= res_valid_next;
        res_reg        <= res_next;
    end

    assign rsp = '{valid_res:  res_valid_reg,
                   peak_out:   res_reg.peak,
                   rms_out:    res_reg.rms,
                   bass_out:   res_reg.bass,
                   mids_out:   res_reg.mids,
                   treble_out: res_reg.treble};

endmodule

@@ hw/rtl/wrac_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrac_ram: point table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wrac_ram (
    input  logic                        clk,
    input  logic                        we,
    input  logic [wrac_pkg::ADDR_W-1:0] waddr,
    input  wrac_pkg::point_t            wdata,
    input  logic [wrac_pkg::ADDR_W-1:0] raddr,
    output wrac_pkg::point_t            rdata
);

    wrac_pkg::point_t mem [wrac_pkg::POINT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/wrac_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrac_div: shared restoring divider
// One quotient bit per cycle; the quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module wrac_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wrac_pkg::PROD_W-1:0] num,
    input  logic [wrac_pkg::DUR_W-1:0]  den,
    output logic                        done,
    output logic [wrac_pkg::QUO_W-1:0]  quo
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [wrac_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [wrac_pkg::DUR_W-1:0]        rem_reg, rem_next;
    logic [wrac_pkg::DUR_W-1:0]        den_reg, den_next;
    logic [wrac_pkg::QUO_W-1:0]        low_reg, low_next;
    logic [wrac_pkg::QUO_W-1:0]        quo_reg, quo_next;
    logic [wrac_pkg::DUR_W:0]          trial;
    logic [wrac_pkg::DUR_W:0]          diff;

    assign trial = {rem_reg, low_reg[wrac_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = wrac_pkg::STEP_W'(wrac_pkg::DIV_STEPS);
            rem_next  = num[wrac_pkg::PROD_W-1:wrac_pkg::QUO_W];
            low_next  = num[wrac_pkg::QUO_W-1:0];
            den_next  = den;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[wrac_pkg::DUR_W-1:0];
                quo_next = {quo_reg[wrac_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[wrac_pkg::DUR_W-1:0];
                quo_next = {quo_reg[wrac_pkg::QUO_W-2:0], 1'b0};
            end
            low_next  = {low_reg[wrac_pkg::QUO_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == wrac_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ hw/rtl/wrac_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrac_checker: port-level assertions
// Checks strobe, busy and invalid-result behavior seen at the top level.
// ----------------------------------------------------------------------------
module wrac_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input wrac_pkg::req_t req,
    input logic           busy,
    input logic           done,
    input wrac_pkg::rsp_t rsp
);

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a transaction");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.cmd == wrac_pkg::CMD_POINT || req.cmd == wrac_pkg::CMD_RANGE))
        |=> busy)
        else $error("query accepted without going busy");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.cmd == wrac_pkg::CMD_LOAD_CUR
                            || req.cmd == wrac_pkg::CMD_LOAD_PREV)) |=> !busy && !done)
        else $error("load transaction produced work");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.valid_res) |-> (rsp.peak_out == '0 && rsp.rms_out == '0
            && rsp.bass_out == '0 && rsp.mids_out == '0 && rsp.treble_out == '0))
        else $error("invalid result carries nonzero fields");

endmodule

bind waveform_range_aggregate_crossfade wrac_checker u_wrac_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

@@ tb/waveform_range_aggregate_crossfade_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_range_aggregate_crossfade_tb: self-checking testbench
// Fills the low part of both point tables, then runs directed and random load,
// point and range transactions over several register settings and sender
// idle rates. A scoreboard predicts each query result, fade blend included,
// and checks every strobed result in order against it.
// ----------------------------------------------------------------------------
module waveform_range_aggregate_crossfade_tb;

    class wave_scoreboard;
        wrac_pkg::point_t cur_tab[wrac_pkg::POINT_DEPTH];
        wrac_pkg::point_t prev_tab[wrac_pkg::POINT_DEPTH];
        longint unsigned cur_cnt, cur_dur, prev_cnt, prev_dur;
        wrac_pkg::rsp_t pending[$];
        int errors;

        function void set_reg(wrac_pkg::cfg_idx_t idx, logic [wrac_pkg::CFG_W-1:0] val);
            case (idx)
                wrac_pkg::CFG_CUR_COUNT:  cur_cnt  = val[wrac_pkg::CNT_W-1:0];
                wrac_pkg::CFG_CUR_DUR:    cur_dur  = val[wrac_pkg::DUR_W-1:0];
                wrac_pkg::CFG_PREV_COUNT: prev_cnt = val[wrac_pkg::CNT_W-1:0];
                wrac_pkg::CFG_PREV_DUR:   prev_dur = val[wrac_pkg::DUR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit lookup(bit use_prev, bit ranged, longint unsigned s,
                            longint unsigned e, output wrac_pkg::point_t p);
            longint unsigned cnt, dur, b, f, n, rs, bs, ms, ts;
            wrac_pkg::point_t q;
            cnt = use_prev ? prev_cnt : cur_cnt;
            dur = use_prev ? prev_dur : cur_dur;
            if (cnt > wrac_pkg::POINT_DEPTH) cnt = wrac_pkg::POINT_DEPTH;
            p = '0;
            if (cnt == 0 || dur == 0) return 0;
            if (ranged && e <= s) e = s + wrac_pkg::RANGE_PAD;
            if (s > dur) s = dur;
            if (e > dur) e = dur;
            b = (s * cnt) / dur;
            if (b > cnt - 1) b = cnt - 1;
            if (!ranged)
            begin
                p = use_prev ? prev_tab[b] : cur_tab[b];
                return 1;
            end
            f = (e * cnt + dur - 1) / dur;
            if (f > cnt) f = cnt;
            if (f < b + 1) f = b + 1;
            rs = 0; bs = 0; ms = 0; ts = 0;
            for (longint unsigned i = b; i < f; i++)
            begin
                q = use_prev ? prev_tab[i] : cur_tab[i];
                if (q.peak > p.peak) p.peak = q.peak;
                rs += q.rms; bs += q.bass; ms += q.mids; ts += q.treble;
            end
            n = f - b;
            p.rms = 16'(rs / n);
            p.bass = 8'(bs / n);
            p.mids = 8'(ms / n);
            p.treble = 8'(ts / n);
            return 1;
        endfunction

        function longint unsigned blend(longint unsigned a, longint unsigned b,
                                        longint unsigned m);
            return (a * (wrac_pkg::MIX_ONE - m) + b * m + wrac_pkg::HALF_LSB) >> 16;
        endfunction

        function void note_input(wrac_pkg::req_t r);
            wrac_pkg::point_t p, cur, prv;
            wrac_pkg::rsp_t x;
            longint unsigned el, m;
            bit ranged;
            p = '{r.peak_in, r.rms_in, r.bass_in, r.mids_in, r.treble_in};
            if (r.cmd == wrac_pkg::CMD_LOAD_CUR)
            begin
                cur_tab[r.entry_index] = p;
                return;
            end
            if (r.cmd == wrac_pkg::CMD_LOAD_PREV)
            begin
                prev_tab[r.entry_index] = p;
                return;
            end
            ranged = (r.cmd == wrac_pkg::CMD_RANGE);
            x = '0;
            if (lookup(0, ranged, r.start_ms, r.end_ms, cur))
            begin
                x = '{1'b1, cur.peak, cur.rms, cur.bass, cur.mids, cur.treble};
                el = r.fade_elapsed_ms;
                if (el < wrac_pkg::FADE_MS)
                begin
                    m = (el * el * (3 * wrac_pkg::FADE_MS - 2 * el) * wrac_pkg::MIX_ONE
                         + wrac_pkg::FADE_DEN / 2) / wrac_pkg::FADE_DEN;
                    if (lookup(1, ranged, r.start_ms, r.end_ms, prv)
                        && m < wrac_pkg::MIX_ONE)
                    begin
                        x.peak_out   = 16'(blend(prv.peak, cur.peak, m));
                        x.rms_out    = 16'(blend(prv.rms, cur.rms, m));
                        x.bass_out   = 8'(blend(prv.bass, cur.bass, m));
                        x.mids_out   = 8'(blend(prv.mids, cur.mids, m));
                        x.treble_out = 8'(blend(prv.treble, cur.treble, m));
                    end
                end
            end
            pending.push_back(x);
        endfunction

        function void check(wrac_pkg::rsp_t got);
            wrac_pkg::rsp_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.valid_res !== want.valid_res || got.peak_out !== want.peak_out ||
                got.rms_out !== want.rms_out || got.bass_out !== want.bass_out ||
                got.mids_out !== want.mids_out || got.treble_out !== want.treble_out)
            begin
                $display("%0t: mismatch expected v=%0d pk=%0d rms=%0d b=%0d m=%0d t=%0d",
                         $time, want.valid_res, want.peak_out, want.rms_out,
                         want.bass_out, want.mids_out, want.treble_out);
                $display("%0t:          actual v=%0d pk=%0d rms=%0d b=%0d m=%0d t=%0d",
                         $time, got.valid_res, got.peak_out, got.rms_out,
                         got.bass_out, got.mids_out, got.treble_out);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    wrac_pkg::req_t req;
    logic busy;
    logic done;
    wrac_pkg::rsp_t rsp;
    logic cfg_write;
    wrac_pkg::cfg_idx_t cfg_index;
    logic [wrac_pkg::CFG_W-1:0] cfg_data;

    wave_scoreboard sb;
    int idle_pct;
    longint unsigned cycles;

    waveform_range_aggregate_crossfade uut (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
        .done(done), .rsp(rsp), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy) sb.note_input(req);
            if (done) sb.check(rsp);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 4000000)
        begin
            $display("** waveform_range_aggregate_crossfade: FAILED **");
            $finish;
        end
    end

    task automatic send(wrac_pkg::req_t r);
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(wrac_pkg::cfg_idx_t idx, logic [wrac_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic configure(int cc, int cd, int pc, int pd);
        settle();
        write_reg(wrac_pkg::CFG_CUR_COUNT, wrac_pkg::CFG_W'(cc));
        write_reg(wrac_pkg::CFG_CUR_DUR, wrac_pkg::CFG_W'(cd));
        write_reg(wrac_pkg::CFG_PREV_COUNT, wrac_pkg::CFG_W'(pc));
        write_reg(wrac_pkg::CFG_PREV_DUR, wrac_pkg::CFG_W'(pd));
    endtask

    function automatic wrac_pkg::req_t rand_req(wrac_pkg::cmd_t c);
        wrac_pkg::req_t r;
        longint unsigned d, s, w;
        r = '0;
        r.cmd = c;
        r.entry_index = 12'($urandom);
        r.peak_in = 16'($urandom);
        r.rms_in = 16'($urandom);
        r.bass_in = 8'($urandom);
        r.mids_in = 8'($urandom);
        r.treble_in = 8'($urandom);
        r.fade_elapsed_ms = ($urandom_range(3) == 0) ? 10'($urandom)
                                                      : 10'($urandom_range(0, 430));
        d = (sb.cur_dur > sb.prev_dur) ? sb.cur_dur : sb.prev_dur;
        if (d == 0) d = 1000;
        case ($urandom_range(19))
            0:
            begin
                r.start_ms = 27'($urandom);
                r.end_ms = 27'($urandom);
            end
            1:
            begin
                r.start_ms = 0;
                r.end_ms = 27'(d * 2);
            end
            default:
            begin
                s = $urandom_range(0, 32'(d + d / 8));
                w = $urandom_range(0, 32'(d / 40 + 1));
                if ($urandom_range(7) == 0) w = 0;
                r.start_ms = 27'(s);
                r.end_ms = 27'(s + w);
            end
        endcase
        return r;
    endfunction

    task automatic random_run(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(9);
            if (k < 2) send(rand_req(wrac_pkg::CMD_LOAD_CUR));
            else if (k < 3) send(rand_req(wrac_pkg::CMD_LOAD_PREV));
            else if (k < 6) send(rand_req(wrac_pkg::CMD_POINT));
            else send(rand_req(wrac_pkg::CMD_RANGE));
        end
    endtask

    // queries kept to the loaded low entries while the counts exceed the depth
    task automatic deep_run(int n);
        wrac_pkg::req_t r;
        int unsigned s;
        for (int i = 0; i < n; i++)
        begin
            r = rand_req(($urandom_range(1) == 0) ? wrac_pkg::CMD_POINT
                                                  : wrac_pkg::CMD_RANGE);
            s = $urandom_range(0, 100000);
            r.start_ms = 27'(s);
            r.end_ms = 27'(s + $urandom_range(0, 20000));
            send(r);
        end
    endtask

    initial
    begin
        wrac_pkg::req_t r;
        sb = new();
        idle_pct = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_write = 1'b0;
        cfg_index = wrac_pkg::CFG_CUR_COUNT;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(rand_req(wrac_pkg::CMD_POINT));
        send(rand_req(wrac_pkg::CMD_RANGE));
        for (int i = 0; i < 128; i++)
        begin
            r = rand_req(wrac_pkg::CMD_LOAD_CUR);
            r.entry_index = 12'(i);
            send(r);
            r = rand_req(wrac_pkg::CMD_LOAD_PREV);
            r.entry_index = 12'(i);
            send(r);
        end

        configure(16, 1000, 8, 1000);
        r = rand_req(wrac_pkg::CMD_LOAD_CUR);
        r.entry_index = '1;
        r.peak_in = '1; r.rms_in = '1; r.bass_in = '1; r.mids_in = '1; r.treble_in = '1;
        send(r);
        r.cmd = wrac_pkg::CMD_LOAD_PREV;
        r.entry_index = '0;
        r.peak_in = '0; r.rms_in = '0; r.bass_in = '0; r.mids_in = '0; r.treble_in = '0;
        send(r);
        for (int j = 0; j < 10; j++)
        begin
            r = rand_req(wrac_pkg::CMD_RANGE);
            r.fade_elapsed_ms = (j % 4 == 0) ? 10'd0 : (j % 4 == 1) ? 10'd419 :
                                (j % 4 == 2) ? 10'd420 : 10'd1023;
            r.start_ms = (j % 3 == 0) ? '1 : 27'(j * 100);
            r.end_ms = (j % 2 == 0) ? r.start_ms : 27'(j * 50);
            send(r);
            r.cmd = wrac_pkg::CMD_POINT;
            send(r);
        end
        r = rand_req(wrac_pkg::CMD_RANGE);
        r.start_ms = 0;
        r.end_ms = '1;
        r.fade_elapsed_ms = 10'd210;
        send(r);

        idle_pct = 0;
        random_run(120);
        configure(128, 86400000, 128, (1 << 27) - 1);
        idle_pct = 51;
        random_run(120);
        configure(128, 1, 0, 500);
        idle_pct = 26;
        random_run(110);
        configure(1, (1 << 27) - 1, 1, 0);
        idle_pct = 0;
        random_run(100);
        configure(0, 7, 100, 300);
        idle_pct = 51;
        random_run(50);
        configure(120, 60000, 100, 55000);
        idle_pct = 26;
        random_run(140);
        configure(64, 0, 8191, 2000);
        idle_pct = 0;
        random_run(60);
        configure(8191, 4096000, 6000, 4096000);
        idle_pct = 26;
        deep_run(60);

        settle();
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("** waveform_range_aggregate_crossfade: PASSED **");
        end
        else
        begin
            $display("** waveform_range_aggregate_crossfade: FAILED **");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/wrac_pkg.sv
hw/rtl/wrac_ram.sv
hw/rtl/wrac_div.sv
hw/rtl/waveform_range_aggregate_crossfade.sv
hw/rtl/wrac_checker.sv
tb/waveform_range_aggregate_crossfade_tb.sv
